// File: rtl/epoch_seconds_to_calendar_date_unit_defines.svh
// Assertion helpers; clk and rst are taken from the module that uses them.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ESCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ESCD_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ESCD_ASSERT(lbl, prop, msg)
`define ESCD_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/escd_pkg.sv
`default_nettype none
package escd_pkg;

  localparam logic [31:0] DAY_SECS  = 32'd86400;
  localparam logic [31:0] HOUR_SECS = 32'd3600;
  localparam logic [31:0] MIN_SECS  = 32'd60;
  localparam logic [31:0] YEAR_SECS = 32'd31536000;
  localparam logic [31:0] LEAP_SECS = 32'd31622400;

  localparam logic [11:0] BASE_YEAR = 12'd2026;
  // year mod 100 and (year / 100) mod 4 of the base year
  localparam logic [6:0]  BASE_Y100 = 7'd26;
  localparam logic [1:0]  BASE_C4   = 2'd0;
  localparam logic [6:0]  Y100_LAST = 7'd99;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;

  // datapath phase codes
  localparam logic [2:0] PH_YEAR  = 3'd0;
  localparam logic [2:0] PH_MONTH = 3'd1;
  localparam logic [2:0] PH_DAY   = 3'd2;
  localparam logic [2:0] PH_HOUR  = 3'd3;
  localparam logic [2:0] PH_MIN   = 3'd4;

  // top quotient bit index of each division phase
  localparam logic [2:0] DAY_TOP  = 3'd4;
  localparam logic [2:0] HOUR_TOP = 3'd4;
  localparam logic [2:0] MIN_TOP  = 3'd5;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       publish;
    logic [2:0] phase;
    logic [2:0] idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic ge;
    logic last_month;
  } dp_status_t;

  // length of a non-leap month in seconds
  function automatic logic [31:0] month_secs(input logic [3:0] m);
    logic [31:0] s;
    case (m)
      4'd2:                       s = 32'd2419200;
      4'd4, 4'd6, 4'd9, 4'd11:    s = 32'd2592000;
      default:                    s = 32'd2678400;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/escd_dpath.sv
`default_nettype none
module escd_dpath (
  input  wire logic                  clk,
  input  wire escd_pkg::ctl_cmd_t    cmd,
  output escd_pkg::dp_status_t       status,
  input  wire logic [31:0]           seconds_count,
  output logic [11:0]                year,
  output logic [3:0]                 month,
  output logic [4:0]                 day,
  output logic [4:0]                 hour,
  output logic [5:0]                 minute,
  output logic [5:0]                 second
);

  logic [31:0] rem;
  logic [11:0] yr;
  logic [6:0]  y100;
  logic [1:0]  c4;
  logic [3:0]  mo;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  min_q;

  logic        leap;
  logic [31:0] sub;
  logic        ge;

  assign leap = ((yr[1:0] == 2'b00) && (y100 != 7'd0)) ||
                ((y100 == 7'd0) && (c4 == 2'd0));

  always_comb begin
    case (cmd.phase)
      escd_pkg::PH_YEAR:  sub = leap ? escd_pkg::LEAP_SECS : escd_pkg::YEAR_SECS;
      escd_pkg::PH_MONTH: sub = escd_pkg::month_secs(mo) +
                                (((mo == escd_pkg::MONTH_FEB) && leap) ?
                                 escd_pkg::DAY_SECS : 32'd0);
      escd_pkg::PH_DAY:   sub = escd_pkg::DAY_SECS << cmd.idx;
      escd_pkg::PH_HOUR:  sub = escd_pkg::HOUR_SECS << cmd.idx;
      escd_pkg::PH_MIN:   sub = escd_pkg::MIN_SECS << cmd.idx;
      default:            sub = escd_pkg::DAY_SECS;
    endcase
  end

  assign ge = rem >= sub;
  assign status.ge = ge;
  assign status.last_month = mo == escd_pkg::MONTH_DEC;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem    <= seconds_count;
      yr     <= escd_pkg::BASE_YEAR;
      y100   <= escd_pkg::BASE_Y100;
      c4     <= escd_pkg::BASE_C4;
      mo     <= escd_pkg::MONTH_JAN;
      day_q  <= 5'd0;
      hour_q <= 5'd0;
      min_q  <= 6'd0;
    end else if (cmd.step && ge) begin
      rem <= rem - sub;
      case (cmd.phase)
        escd_pkg::PH_YEAR: begin
          yr <= yr + 12'd1;
          if (y100 == escd_pkg::Y100_LAST) begin
            y100 <= 7'd0;
            c4   <= c4 + 2'd1;
          end else begin
            y100 <= y100 + 7'd1;
          end
        end
        escd_pkg::PH_MONTH: mo <= mo + 4'd1;
        escd_pkg::PH_DAY:   day_q[cmd.idx] <= 1'b1;
        escd_pkg::PH_HOUR:  hour_q[cmd.idx] <= 1'b1;
        escd_pkg::PH_MIN:   min_q[cmd.idx] <= 1'b1;
        default: ;
      endcase
    end
  end

  // output word register, separate from the working registers
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      year   <= yr;
      month  <= mo;
      day    <= day_q + 5'd1;
      hour   <= hour_q;
      minute <= min_q;
      second <= rem[5:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/escd_ctrl.sv
`default_nettype none
`include "epoch_seconds_to_calendar_date_unit_defines.svh"
module escd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output escd_pkg::ctl_cmd_t        cmd,
  input  wire escd_pkg::dp_status_t status
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_YEAR   = 3'd1;
  localparam logic [2:0] ST_MONTH  = 3'd2;
  localparam logic [2:0] ST_DAY    = 3'd3;
  localparam logic [2:0] ST_HOUR   = 3'd4;
  localparam logic [2:0] ST_MIN    = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] idx, idx_next;
  logic       out_valid_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    cmd.phase   = escd_pkg::PH_YEAR;
    cmd.idx     = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        cmd.step = 1'b1;
        if (!status.ge) state_next = ST_MONTH;
      end
      ST_MONTH: begin
        cmd.phase = escd_pkg::PH_MONTH;
        cmd.step  = !status.last_month;
        if (!status.ge || status.last_month) begin
          state_next = ST_DAY;
          idx_next   = escd_pkg::DAY_TOP;
        end
      end
      ST_DAY: begin
        cmd.phase = escd_pkg::PH_DAY;
        cmd.step  = 1'b1;
        if (idx == 3'd0) begin
          state_next = ST_HOUR;
          idx_next   = escd_pkg::HOUR_TOP;
        end else begin
          idx_next = idx - 3'd1;
        end
      end
      ST_HOUR: begin
        cmd.phase = escd_pkg::PH_HOUR;
        cmd.step  = 1'b1;
        if (idx == 3'd0) begin
          state_next = ST_MIN;
          idx_next   = escd_pkg::MIN_TOP;
        end else begin
          idx_next = idx - 3'd1;
        end
      end
      ST_MIN: begin
        cmd.phase = escd_pkg::PH_MIN;
        cmd.step  = 1'b1;
        if (idx == 3'd0) state_next = ST_FINISH;
        else idx_next = idx - 3'd1;
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  `ESCD_ASSERT(a_year_exit, (state == ST_YEAR && !status.ge) |=> state == ST_MONTH, "year walk did not exit")
  `ESCD_NEVER(a_month_overrun, cmd.step && cmd.phase == escd_pkg::PH_MONTH && status.last_month, "month stepped past December")
  `ESCD_ASSERT(a_publish, cmd.publish |=> (out_valid && state == ST_IDLE), "publish lost")
  `ESCD_NEVER(a_load_busy, cmd.load && state != ST_IDLE, "word loaded while busy")

endmodule
`default_nettype wire

// File: rtl/epoch_seconds_to_calendar_date_unit.sv
// From input accept to output valid, the controller removes whole years, then whole months
// (up to December), then finds the day, hour and minute quotient bits, then publishes.
// A new input is taken only in idle, after the previous word is published; the shared
// 32-bit compare-and-subtract sets the pace. A finished word waits in its output register
// while the next input is taken; the next publish holds until that register is free.
// Reset (rst, synchronous) returns the controller to idle and clears out_valid.
`default_nettype none
module epoch_seconds_to_calendar_date_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] seconds_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second
);

  escd_pkg::ctl_cmd_t   cmd;
  escd_pkg::dp_status_t status;

  escd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  escd_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .seconds_count (seconds_count),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second)
  );

endmodule
`default_nettype wire
